### sv/counter_wrap_extend_accumulator_unit_macros.svh
// ----------------------------------------------------------------------------
// Counter wrap extend accumulator assertion macros
// Shared concurrent assertion forms for the accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef COUNTER_WRAP_EXTEND_ACCUMULATOR_UNIT_MACROS_SVH
`define COUNTER_WRAP_EXTEND_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication, masked while in reset
`define CWEA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cwea assertion failed");

// next-cycle implication, also checked across reset
`define CWEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cwea assertion failed");

`endif

### sv/cwea_pkg.sv
// ----------------------------------------------------------------------------
// Counter wrap extend accumulator package
// Shared constants, codes, item types and helper functions.
// ----------------------------------------------------------------------------
package cwea_pkg;

  // sizes
  localparam int NCNT        = 8;
  localparam int CNT_W       = 64;
  localparam int HALF_W      = 32;
  localparam int SIG_W       = 32;
  localparam int HOLD_W      = 8;
  localparam int TIMER_WIDTH = 8;
  localparam int CFG_IDX_W   = 2;

  // lanes that carry byte counters
  localparam int LANE_RX_OCTETS = 2;
  localparam int LANE_TX_OCTETS = 3;

  // op codes
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_RESET  = 2'd1;
  localparam logic [1:0] OP_REBASE = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIGNIFICANT_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_HOLD_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD_TICKS   = 2'd2;

  // register reset values
  localparam logic [SIG_W-1:0]  SIG_BYTES_RESET  = 32'd1024;
  localparam logic [HOLD_W-1:0] SHORT_HOLD_RESET = 8'd2;
  localparam logic [HOLD_W-1:0] LONG_HOLD_RESET  = 8'd30;

  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [TIMER_WIDTH-1:0] timer_t;

  typedef struct packed {
    logic [1:0] op;
    cnt_t rx_pkt_cnt;
    cnt_t tx_pkt_cnt;
    cnt_t rx_byte_cnt;
    cnt_t tx_byte_cnt;
    cnt_t rx_err_cnt;
    cnt_t tx_err_cnt;
    cnt_t rx_drop_cnt;
    cnt_t tx_drop_cnt;
  } item_t;

  typedef struct packed {
    cnt_t rx_pkt_total;
    cnt_t tx_pkt_total;
    cnt_t rx_byte_total;
    cnt_t tx_byte_total;
    cnt_t rx_err_total;
    cnt_t tx_err_total;
    cnt_t rx_drop_total;
    cnt_t tx_drop_total;
    logic save_request;
    logic snapshot_discarded;
    logic unsaved_changes;
  } result_t;

  typedef struct packed {
    logic [SIG_W-1:0]  significant_bytes;
    logic [HOLD_W-1:0] short_hold_ticks;
    logic [HOLD_W-1:0] long_hold_ticks;
  } cfg_t;

  // broadcast from the merge stage to every lane
  typedef struct packed {
    logic update;
    logic rebase;
    logic clear;
  } lane_ctrl_t;

  // what one lane found for its counter
  typedef struct packed {
    logic same;
    logic back;
    logic wide;
    cnt_t delta;
  } lane_status_t;

  typedef struct packed {
    logic save_request;
    logic snapshot_discarded;
    logic unsaved_changes;
  } flags_t;

  // hold register to timer width: mask when narrower, zero-fill when wider
  function automatic timer_t hold_to_timer(logic [HOLD_W-1:0] h);
    timer_t t;
    t = '0;
    for (int i = 0; i < TIMER_WIDTH; i++) begin
      if (i < HOLD_W) t[i] = h[i];
    end
    return t;
  endfunction

endpackage

### sv/cwea_item_if.sv
// ----------------------------------------------------------------------------
// Counter snapshot channel
// Valid/ready channel that carries one op and a counter snapshot per item.
// ----------------------------------------------------------------------------
interface cwea_item_if
  import cwea_pkg::*;
;
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/cwea_result_if.sv
// ----------------------------------------------------------------------------
// Accumulator result channel
// Valid/ready channel that carries totals and status flags per item.
// ----------------------------------------------------------------------------
interface cwea_result_if
  import cwea_pkg::*;
;
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/cwea_lane.sv
// ----------------------------------------------------------------------------
// Counter lane
// Holds one counter's last snapshot and total, finds its delta with 32-bit
// wrap extension and updates both under control of the merge stage.
// ----------------------------------------------------------------------------
module cwea_lane
  import cwea_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cnt_t         snap,
  input  lane_ctrl_t   ctrl,
  output lane_status_t status,
  output cnt_t         total_next
);

  cnt_t             last_snapshot;
  cnt_t             running_total;
  cnt_t             last_next;
  cnt_t             ext_snap;
  logic [CNT_W:0]   diff;
  logic             lo_borrow;
  logic [HALF_W-1:0] hi_ext;

  // full difference, borrow marks a backward counter
  assign diff      = {1'b0, snap} - {1'b0, last_snapshot};
  assign lo_borrow = snap[HALF_W-1:0] < last_snapshot[HALF_W-1:0];
  assign hi_ext    = last_snapshot[CNT_W-1:HALF_W] + HALF_W'(lo_borrow);

  // backward counter keeps the old upper half, one more if the low half wrapped
  assign ext_snap = diff[CNT_W] ? {hi_ext, snap[HALF_W-1:0]} : snap;

  always_comb begin
    status.same  = (snap == last_snapshot);
    status.back  = diff[CNT_W];
    status.wide  = |snap[CNT_W-1:HALF_W];
    status.delta = diff[CNT_W] ? {{(CNT_W-HALF_W){1'b0}}, diff[HALF_W-1:0]}
                               : diff[CNT_W-1:0];
  end

  // next total and last snapshot
  always_comb begin
    total_next = running_total;
    last_next  = last_snapshot;
    if (ctrl.clear) begin
      total_next = '0;
    end else if (ctrl.update) begin
      total_next = running_total + status.delta;
      last_next  = ext_snap;
    end else if (ctrl.rebase) begin
      last_next  = snap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_snapshot <= '0;
      running_total <= '0;
    end else begin
      last_snapshot <= last_next;
      running_total <= total_next;
    end
  end

endmodule

### sv/cwea_merge.sv
// ----------------------------------------------------------------------------
// Lane merge and save control
// Combines lane findings, keeps the byte change count, dirty flag and
// hold-off timers, and decides saves and discards for each item.
// ----------------------------------------------------------------------------
module cwea_merge
  import cwea_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [1:0]   op,
  input  cfg_t         cfg,
  input  lane_status_t status [NCNT],
  output lane_ctrl_t   ctrl,
  output flags_t       flags
);

  `include "counter_wrap_extend_accumulator_unit_macros.svh"

  cnt_t   bytes_since_save;
  cnt_t   bytes_next;
  cnt_t   bytes_sum;
  logic   dirty_flag;
  logic   dirty_next;
  timer_t short_timer;
  timer_t short_next;
  timer_t long_timer;
  timer_t long_next;
  timer_t short_dec;
  timer_t long_dec;
  logic   short_fire;
  logic   long_fire;
  logic   sig_now;
  logic   sig_after;
  logic   all_same;
  logic   any_back;
  logic   any_wide;
  logic   save;
  logic   discarded;

  // combine lane flags
  always_comb begin
    all_same = 1'b1;
    any_back = 1'b0;
    any_wide = 1'b0;
    for (int i = 0; i < NCNT; i++) begin
      all_same = all_same & status[i].same;
      any_back = any_back | status[i].back;
      any_wide = any_wide | status[i].wide;
    end
  end

  // byte change count and significance
  assign bytes_sum = bytes_since_save + status[LANE_RX_OCTETS].delta
                     + status[LANE_TX_OCTETS].delta;
  assign sig_now   = bytes_since_save >= cnt_t'(cfg.significant_bytes);
  assign sig_after = bytes_sum >= cnt_t'(cfg.significant_bytes);

  // timer countdown for a tick
  assign short_dec  = (short_timer != '0) ? short_timer - timer_t'(1) : short_timer;
  assign long_dec   = (long_timer != '0) ? long_timer - timer_t'(1) : long_timer;
  assign short_fire = (short_timer != '0) && (short_dec == '0);
  assign long_fire  = (long_timer != '0) && (long_dec == '0);

  // per-op decision
  always_comb begin
    ctrl       = '0;
    save       = 1'b0;
    discarded  = 1'b0;
    bytes_next = bytes_since_save;
    dirty_next = dirty_flag;
    short_next = short_timer;
    long_next  = long_timer;
    if (fire) begin
      case (op)
        OP_UPDATE: begin
          if (!all_same) begin
            if (any_back && any_wide) begin
              discarded = 1'b1;
            end else begin
              ctrl.update = 1'b1;
              dirty_next  = 1'b1;
              bytes_next  = bytes_sum;
              save        = sig_after ? (short_timer == '0) : (long_timer == '0);
            end
          end
        end
        OP_RESET: begin
          ctrl.clear = 1'b1;
          save       = 1'b1;
        end
        OP_REBASE: begin
          ctrl.rebase = 1'b1;
          save        = 1'b1;
        end
        default: begin
          short_next = short_dec;
          long_next  = long_dec;
          save       = (short_fire && sig_now) || (long_fire && dirty_flag);
        end
      endcase
    end
    // a save clears the change count and reloads both hold-offs
    if (save) begin
      bytes_next = '0;
      dirty_next = 1'b0;
      short_next = hold_to_timer(cfg.short_hold_ticks);
      long_next  = hold_to_timer(cfg.long_hold_ticks);
    end
  end

  always_comb begin
    flags.save_request       = save;
    flags.snapshot_discarded = discarded;
    flags.unsaved_changes    = dirty_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_since_save <= '0;
      dirty_flag       <= 1'b0;
      short_timer      <= '0;
      long_timer       <= '0;
    end else begin
      bytes_since_save <= bytes_next;
      dirty_flag       <= dirty_next;
      short_timer      <= short_next;
      long_timer       <= long_next;
    end
  end

  // assertions
  `CWEA_ASSERT_IMPL(a_lane_ctrl_onehot, 1'b1, $onehot0({ctrl.update, ctrl.rebase, ctrl.clear}))
  `CWEA_ASSERT_IMPL(a_discard_keeps_state, discarded, !save && !ctrl.update)
  `CWEA_ASSERT_IMPL(a_clean_is_zero, !dirty_flag && !fire, bytes_next == bytes_since_save)

endmodule

### sv/counter_wrap_extend_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Counter wrap extend accumulator unit
// Accumulates eight interface counter snapshots into 64-bit totals.
// ----------------------------------------------------------------------------
// Usage:
//   snapshot carries one item per handshake: an op and eight counter values.
//   result returns exactly one item per accepted snapshot item: the eight
//   totals after the op, save_request, snapshot_discarded and
//   unsaved_changes.
//   cfg_write / cfg_index / cfg_data write significant_bytes (0),
//   short_hold_ticks (1) and long_hold_ticks (2); other indexes are ignored.
//   Write them only while no item is in flight.
// Throughput: one item per cycle while result.ready is high; a result
//   appears in the cycle after its item is taken. All eight lanes and the
//   merge stage act on an item in the cycle it is accepted, then the output
//   register holds the result.
// Reset (rst, synchronous): totals, last snapshot, change count, dirty flag
//   and timers go to zero, registers return to 1024, 2 and 30.
// Stall: while a result waits on result.ready, snapshot.ready is low;
//   it rises again in the cycle the waiting result is taken.
// ----------------------------------------------------------------------------
module counter_wrap_extend_accumulator_unit
  import cwea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  cwea_item_if.sink            snapshot,
  cwea_result_if.source        result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIG_W-1:0]     cfg_data
);

  `include "counter_wrap_extend_accumulator_unit_macros.svh"

  cfg_t         cfg;
  logic         fire;
  cnt_t         snap [NCNT];
  cnt_t         total_next [NCNT];
  lane_status_t status [NCNT];
  lane_ctrl_t   ctrl;
  flags_t       flags;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.significant_bytes <= SIG_BYTES_RESET;
      cfg.short_hold_ticks  <= SHORT_HOLD_RESET;
      cfg.long_hold_ticks   <= LONG_HOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SIGNIFICANT_BYTES: cfg.significant_bytes <= cfg_data;
        REG_SHORT_HOLD_TICKS:  cfg.short_hold_ticks  <= cfg_data[HOLD_W-1:0];
        REG_LONG_HOLD_TICKS:   cfg.long_hold_ticks   <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign snapshot.ready = !result.valid || result.ready;
  assign fire           = snapshot.valid && snapshot.ready;

  // snapshot fields to lanes
  assign snap[0] = snapshot.data.rx_pkt_cnt;
  assign snap[1] = snapshot.data.tx_pkt_cnt;
  assign snap[2] = snapshot.data.rx_byte_cnt;
  assign snap[3] = snapshot.data.tx_byte_cnt;
  assign snap[4] = snapshot.data.rx_err_cnt;
  assign snap[5] = snapshot.data.tx_err_cnt;
  assign snap[6] = snapshot.data.rx_drop_cnt;
  assign snap[7] = snapshot.data.tx_drop_cnt;

  // counter lanes
  for (genvar g = 0; g < NCNT; g++) begin : g_lane
    cwea_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .snap       (snap[g]),
      .ctrl       (ctrl),
      .status     (status[g]),
      .total_next (total_next[g])
    );
  end

  // merge stage
  cwea_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .op     (snapshot.data.op),
    .cfg    (cfg),
    .status (status),
    .ctrl   (ctrl),
    .flags  (flags)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.data.rx_pkt_total       <= total_next[0];
      result.data.tx_pkt_total       <= total_next[1];
      result.data.rx_byte_total      <= total_next[2];
      result.data.tx_byte_total      <= total_next[3];
      result.data.rx_err_total       <= total_next[4];
      result.data.tx_err_total       <= total_next[5];
      result.data.rx_drop_total      <= total_next[6];
      result.data.tx_drop_total      <= total_next[7];
      result.data.save_request       <= flags.save_request;
      result.data.snapshot_discarded <= flags.snapshot_discarded;
      result.data.unsaved_changes    <= flags.unsaved_changes;
    end
  end

  // assertions
  `CWEA_ASSERT_NEXT(a_accept_gives_result, fire && !rst, result.valid)
  `CWEA_ASSERT_NEXT(a_reset_empties, rst, !result.valid)
  `CWEA_ASSERT_IMPL(a_save_is_clean, result.valid && result.data.save_request,
                    !result.data.unsaved_changes)
  `CWEA_ASSERT_IMPL(a_discard_no_save, result.valid && result.data.snapshot_discarded,
                    !result.data.save_request)

endmodule

### tb/sv/counter_wrap_extend_accumulator_unit_test.sv
// ----------------------------------------------------------------------------
// Counter wrap extend accumulator testbench
// Drives op and counter snapshot items through the valid/ready channel and
// checks every result item against an in-bench model of the totals, the
// 32-bit wrap extension, discards and the save hold-off timers. A short
// table of directed items comes first, then random phases under several
// register settings with random idling on both sides.
// ----------------------------------------------------------------------------
module counter_wrap_extend_accumulator_unit_test;
  import cwea_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RX_STALL_CYCLES = 300;
  localparam int PHASES          = 7;
  localparam int PHASE_ITEMS     = 100;
  localparam int FLAG_W          = 3;
  localparam int NO_LANE         = -1;
  localparam int LANE_RX_PKTS    = 0;
  localparam int LANE_TX_PKTS    = 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam cnt_t ALL_ONES = {CNT_W{1'b1}};
  localparam cnt_t LOW_WORD = 64'h0000_0000_FFFF_FFFF;

  // one directed item: a fill value for all lanes with up to two overrides
  typedef struct packed {
    logic [1:0] op;
    cnt_t       fill;
    int         lane_a;
    cnt_t       val_a;
    int         lane_b;
    cnt_t       val_b;
    bit         typed;
    bit         t_save;
    bit         t_drop;
    bit         t_dirty;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIG_W-1:0]     cfg_data = '0;

  cwea_item_if   snap_if ();
  cwea_result_if res_if ();

  counter_wrap_extend_accumulator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .snapshot  (snap_if),
    .result    (res_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // model state, mirrors the block after reset
  cnt_t              last_seen [NCNT] = '{default: '0};
  cnt_t              acc_total [NCNT] = '{default: '0};
  cnt_t              byte_change = '0;
  bit                dirty = 1'b0;
  timer_t            short_left = '0;
  timer_t            long_left = '0;
  logic [SIG_W-1:0]  sig_bytes_cfg = SIG_BYTES_RESET;
  logic [HOLD_W-1:0] short_cfg = SHORT_HOLD_RESET;
  logic [HOLD_W-1:0] long_cfg = LONG_HOLD_RESET;

  // stimulus shaping and bookkeeping
  cnt_t     gen_base [NCNT] = '{default: '0};
  result_t  totals_due [$];
  dir_row_t dir_rows [$];
  result_t  want_now;
  bit       tx_idling = 1'b1;
  bit       rx_idling = 1'b1;
  bit       hold_out_req = 1'b0;
  int       cycle_count = 0;
  int       mismatches = 0;
  int       items_sent = 0;
  int       results_seen = 0;
  int       saves_seen = 0;
  int       drops_seen = 0;

  string total_names [NCNT] = '{"rx_pkt_total", "tx_pkt_total", "rx_byte_total",
                                "tx_byte_total", "rx_err_total", "tx_err_total",
                                "rx_drop_total", "tx_drop_total"};
  string flag_names [FLAG_W] = '{"unsaved_changes", "snapshot_discarded", "save_request"};

  function automatic item_t pack_item(logic [1:0] op, cnt_t lanes [NCNT]);
    logic [NCNT*CNT_W-1:0] flat;
    int i;
    for (i = 0; i < NCNT; i++) flat[(NCNT-1-i)*CNT_W +: CNT_W] = lanes[i];
    return item_t'({op, flat});
  endfunction

  function automatic bit change_is_significant();
    return byte_change >= {{(CNT_W-SIG_W){1'b0}}, sig_bytes_cfg};
  endfunction

  // advance the model by one item and return the result it should produce
  function automatic result_t advance_counters(item_t it);
    logic [NCNT*CNT_W-1:0] flat;
    cnt_t lanes [NCNT];
    bit   same, back, wide, saving, dropped, short_hit, long_hit;
    int   i;
    flat = it[NCNT*CNT_W-1:0];
    for (i = 0; i < NCNT; i++) lanes[i] = flat[(NCNT-1-i)*CNT_W +: CNT_W];
    saving = 1'b0;
    dropped = 1'b0;
    case (it.op)
      OP_UPDATE: begin
        same = 1'b1;
        back = 1'b0;
        wide = 1'b0;
        for (i = 0; i < NCNT; i++) begin
          if (lanes[i] != last_seen[i]) same = 1'b0;
          if (lanes[i] < last_seen[i]) back = 1'b1;
          if (lanes[i][CNT_W-1:HALF_W] != '0) wide = 1'b1;
        end
        if (!same) begin
          if (back && wide) begin
            dropped = 1'b1;
          end else begin
            // backward lanes borrow the old upper word, then step past a wrap
            for (i = 0; i < NCNT; i++) begin
              if (lanes[i] < last_seen[i]) begin
                lanes[i] = lanes[i] | {last_seen[i][CNT_W-1:HALF_W], {HALF_W{1'b0}}};
                if (lanes[i] < last_seen[i]) lanes[i] = lanes[i] + (cnt_t'(1) << HALF_W);
              end
            end
            byte_change = byte_change + (lanes[LANE_RX_OCTETS] - last_seen[LANE_RX_OCTETS])
                        + (lanes[LANE_TX_OCTETS] - last_seen[LANE_TX_OCTETS]);
            for (i = 0; i < NCNT; i++) begin
              acc_total[i] = acc_total[i] + (lanes[i] - last_seen[i]);
              last_seen[i] = lanes[i];
            end
            dirty = 1'b1;
            if (change_is_significant()) saving = (short_left == '0);
            else saving = (long_left == '0);
          end
        end
      end
      OP_RESET: begin
        for (i = 0; i < NCNT; i++) acc_total[i] = '0;
        saving = 1'b1;
      end
      OP_REBASE: begin
        for (i = 0; i < NCNT; i++) last_seen[i] = lanes[i];
        saving = 1'b1;
      end
      OP_TICK: begin
        short_hit = 1'b0;
        long_hit = 1'b0;
        if (short_left != '0) begin
          short_left = short_left - timer_t'(1);
          short_hit = (short_left == '0);
        end
        if (long_left != '0) begin
          long_left = long_left - timer_t'(1);
          long_hit = (long_left == '0);
        end
        // short hold-off wins when both run out together
        if (short_hit && change_is_significant()) saving = 1'b1;
        else if (long_hit && dirty) saving = 1'b1;
      end
    endcase
    if (saving) begin
      byte_change = '0;
      dirty = 1'b0;
      short_left = timer_t'(short_cfg);
      long_left = timer_t'(long_cfg);
    end
    for (i = 0; i < NCNT; i++) flat[(NCNT-1-i)*CNT_W +: CNT_W] = acc_total[i];
    return result_t'({flat, saving, dropped, dirty});
  endfunction

  // random item: ticks, resets, rebases, and updates whose counters mostly move forward, with wraps and noise
  function automatic item_t next_random_item();
    cnt_t       lanes [NCNT];
    cnt_t       inc;
    logic [1:0] op;
    int         pick, kind, i, k;
    for (i = 0; i < NCNT; i++) lanes[i] = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      op = OP_TICK;
    end else if (pick < 34) begin
      op = OP_RESET;
    end else if (pick < 42) begin
      op = OP_REBASE;
      kind = $urandom_range(0, 3);
      for (i = 0; i < NCNT; i++) begin
        case (kind)
          0: lanes[i] = {32'd0, 24'hFF_FFFF, 8'($urandom)};
          1: lanes[i] = {32'd0, $urandom};
          2: lanes[i] = '0;
          default: ;
        endcase
      end
      gen_base = lanes;
    end else begin
      op = OP_UPDATE;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // counters that fit 32 bits wrap as 32-bit hardware counters do
        for (i = 0; i < NCNT; i++) begin
          kind = $urandom_range(0, 9);
          if (i != LANE_RX_OCTETS && i != LANE_TX_OCTETS) inc = cnt_t'($urandom_range(0, 3));
          else if (kind < 6) inc = cnt_t'($urandom_range(0, 15));
          else if (kind < 9) inc = cnt_t'($urandom_range(0, 4000));
          else inc = {32'd0, $urandom};
          if (gen_base[i][CNT_W-1:HALF_W] == '0)
            lanes[i] = {32'd0, gen_base[i][HALF_W-1:0] + inc[HALF_W-1:0]};
          else
            lanes[i] = gen_base[i] + inc;
        end
        gen_base = lanes;
      end else if (pick < 70) begin
        lanes = gen_base;
      end else if (pick < 80) begin
        // one counter steps back while another shows upper bits
        lanes = gen_base;
        k = $urandom_range(0, NCNT - 1);
        lanes[k] = gen_base[k] - cnt_t'($urandom_range(1, 4));
        lanes[(k + 1) % NCNT] = {$urandom | 32'd1, $urandom};
      end else if (pick < 88) begin
        for (i = 0; i < NCNT; i++) lanes[i] = gen_base[i] + {32'd0, $urandom};
        gen_base = lanes;
      end
    end
    return pack_item(op, lanes);
  endfunction

  // hand one item over and wait for it to be taken
  task automatic offer(item_t it);
    snap_if.valid <= 1'b1;
    snap_if.data <= it;
    do @(posedge clk); while (!snap_if.ready);
    items_sent++;
  endtask

  task automatic sender_gap();
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      snap_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    snap_if.valid <= 1'b0;
    do @(posedge clk); while (totals_due.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // hold registers take the low byte, so random junk goes above it
  task automatic program_regs(logic [SIG_W-1:0] sig, logic [HOLD_W-1:0] sh,
                              logic [HOLD_W-1:0] lg);
    write_reg(REG_SIGNIFICANT_BYTES, sig);
    write_reg(REG_SHORT_HOLD_TICKS, {24'($urandom), sh});
    write_reg(REG_LONG_HOLD_TICKS, {24'($urandom), lg});
    if ($urandom_range(0, 1) == 0) write_reg(REG_UNUSED, $urandom);
    cfg_write <= 1'b0;
    sig_bytes_cfg = sig;
    short_cfg = sh;
    long_cfg = lg;
  endtask

  task automatic add_row(logic [1:0] op, cnt_t fill, int lane_a, cnt_t val_a, int lane_b,
                         cnt_t val_b, bit typed, bit t_save, bit t_drop, bit t_dirty);
    dir_rows.push_back('{op, fill, lane_a, val_a, lane_b, val_b, typed, t_save, t_drop,
                         t_dirty});
  endtask

  task automatic check_result(result_t want, result_t got);
    int i;
    for (i = 0; i < NCNT; i++) begin
      if (want[FLAG_W+(NCNT-1-i)*CNT_W +: CNT_W] !== got[FLAG_W+(NCNT-1-i)*CNT_W +: CNT_W]) begin
        $display("%0t: %s expected %h actual %h", $time, total_names[i],
                 want[FLAG_W+(NCNT-1-i)*CNT_W +: CNT_W], got[FLAG_W+(NCNT-1-i)*CNT_W +: CNT_W]);
        mismatches++;
      end
    end
    for (i = 0; i < FLAG_W; i++) begin
      if (want[i] !== got[i]) begin
        $display("%0t: %s expected %b actual %b", $time, flag_names[i], want[i], got[i]);
        mismatches++;
      end
    end
  endtask

  // run length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (totals_due.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, res_if.data);
        mismatches++;
      end else begin
        want_now = totals_due.pop_front();
        check_result(want_now, res_if.data);
        results_seen++;
        if (res_if.data.save_request === 1'b1) saves_seen++;
        if (res_if.data.snapshot_discarded === 1'b1) drops_seen++;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_side
    res_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (RX_STALL_CYCLES) @(posedge clk);
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // snapshot side
  initial begin : snapshot_side
    cnt_t    lanes [NCNT];
    item_t   it;
    result_t want;
    int      r, p, n, i;
    snap_if.valid <= 1'b0;
    snap_if.data <= '0;

    // directed items, run under the reset register values
    add_row(OP_UPDATE, 64'd0, NO_LANE, 64'd0, NO_LANE, 64'd0, 1, 0, 0, 0);
    add_row(OP_UPDATE, 64'd0, LANE_RX_PKTS, 64'd10, LANE_RX_OCTETS, 64'd100, 0, 0, 0, 0);
    add_row(OP_UPDATE, 64'd0, LANE_RX_PKTS, 64'd20, LANE_RX_OCTETS, 64'd2000, 0, 0, 0, 0);
    add_row(OP_TICK, 64'd0, NO_LANE, 64'd0, NO_LANE, 64'd0, 0, 0, 0, 0);
    add_row(OP_TICK, 64'd0, NO_LANE, 64'd0, NO_LANE, 64'd0, 0, 0, 0, 0);
    add_row(OP_UPDATE, LOW_WORD, NO_LANE, 64'd0, NO_LANE, 64'd0, 0, 0, 0, 0);
    // 32-bit wraps: plain, from an extended value, and one that needs no extra step
    add_row(OP_UPDATE, LOW_WORD, LANE_RX_PKTS, 64'd5, NO_LANE, 64'd0, 0, 0, 0, 0);
    add_row(OP_UPDATE, LOW_WORD, LANE_RX_PKTS, 64'd3, NO_LANE, 64'd0, 0, 0, 0, 0);
    add_row(OP_UPDATE, LOW_WORD, LANE_RX_PKTS, 64'd16, NO_LANE, 64'd0, 0, 0, 0, 0);
    // backward with upper bits set, then a wide forward step
    add_row(OP_UPDATE, ALL_ONES, LANE_TX_PKTS, 64'd0, NO_LANE, 64'd0, 0, 0, 0, 0);
    add_row(OP_UPDATE, ALL_ONES, NO_LANE, 64'd0, NO_LANE, 64'd0, 0, 0, 0, 0);
    add_row(OP_RESET, 64'd0, NO_LANE, 64'd0, NO_LANE, 64'd0, 1, 1, 0, 0);
    // all ones back to zero wraps every total by one
    add_row(OP_UPDATE, 64'd0, NO_LANE, 64'd0, NO_LANE, 64'd0, 0, 0, 0, 0);
    add_row(OP_REBASE, ALL_ONES, NO_LANE, 64'd0, NO_LANE, 64'd0, 0, 0, 0, 0);
    add_row(OP_RESET, 64'd0, NO_LANE, 64'd0, NO_LANE, 64'd0, 1, 1, 0, 0);
    add_row(OP_UPDATE, ALL_ONES, LANE_RX_PKTS, 64'hFFFF_FFFF_0000_0000, NO_LANE, 64'd0,
            1, 0, 1, 0);
    add_row(OP_UPDATE, ALL_ONES, NO_LANE, 64'd0, NO_LANE, 64'd0, 1, 0, 0, 0);
    add_row(OP_REBASE, 64'd0, NO_LANE, 64'd0, NO_LANE, 64'd0, 1, 1, 0, 0);
    add_row(OP_UPDATE, 64'd0, LANE_TX_OCTETS, 64'd5, NO_LANE, 64'd0, 0, 0, 0, 0);
    add_row(OP_TICK, 64'hA5A5_A5A5_A5A5_A5A5, NO_LANE, 64'd0, NO_LANE, 64'd0, 0, 0, 0, 0);
    add_row(OP_REBASE, 64'h5A5A_5A5A_5A5A_5A5A, NO_LANE, 64'd0, NO_LANE, 64'd0, 0, 0, 0, 0);
    add_row(OP_TICK, ALL_ONES, NO_LANE, 64'd0, NO_LANE, 64'd0, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < dir_rows.size(); r++) begin
      for (i = 0; i < NCNT; i++) lanes[i] = dir_rows[r].fill;
      if (dir_rows[r].lane_a != NO_LANE) lanes[dir_rows[r].lane_a] = dir_rows[r].val_a;
      if (dir_rows[r].lane_b != NO_LANE) lanes[dir_rows[r].lane_b] = dir_rows[r].val_b;
      it = pack_item(dir_rows[r].op, lanes);
      offer(it);
      want = advance_counters(it);
      if (dir_rows[r].typed)
        want = result_t'({{(NCNT*CNT_W){1'b0}}, dir_rows[r].t_save, dir_rows[r].t_drop,
                          dir_rows[r].t_dirty});
      totals_due.push_back(want);
      sender_gap();
    end
    drain();
    gen_base = last_seen;

    // random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(32'd1, 8'd1, 8'd1);
        1: program_regs(32'd0, 8'd0, 8'd0);
        2: program_regs({SIG_W{1'b1}}, {HOLD_W{1'b1}}, {HOLD_W{1'b1}});
        3: program_regs(32'd200, 8'd3, 8'd7);
        4, 5: program_regs(SIG_W'($urandom_range(1, 5000)), HOLD_W'($urandom_range(1, 12)),
                           HOLD_W'($urandom_range(1, 40)));
        default: program_regs(SIG_BYTES_RESET, SHORT_HOLD_RESET, LONG_HOLD_RESET);
      endcase
      tx_idling = (p != 1) && (p != PHASES - 1);
      rx_idling = (p != 3) && (p != PHASES - 1);
      // output held off while items keep coming, so the input stalls
      if (p == 2) hold_out_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // sender waits for every result before going on
        if (p == 4 && n == PHASE_ITEMS / 2) drain();
        it = next_random_item();
        offer(it);
        totals_due.push_back(advance_counters(it));
        sender_gap();
      end
      drain();
    end

    repeat (4) @(posedge clk);
    $display("ran %0d items, checked %0d results: %0d save requests, %0d discards",
             items_sent, results_seen, saves_seen, drops_seen);
    $display("covered reset, extreme and random register settings with stalls and drains");
    if (mismatches == 0 && totals_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
